FILE: rtl/core/frp_pkg.sv
`default_nettype none
package frp_pkg;

    // payload buffer size and derived widths
    localparam int PAYLOAD_BYTES = 64;
    localparam int OFS_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int BANKS         = 2;
    localparam int BANK_W        = 1;
    localparam int RAM_DEPTH     = BANKS * (2 ** OFS_W);
    localparam int RAM_AW        = BANK_W + OFS_W;

    // fixed field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int IDX_W  = 6;
    localparam int CRC_W  = 16;
    localparam int CFG_IW = 1;

    localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;
    localparam logic [BYTE_W-1:0] SOF0_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] SOF1_RST = 8'h55;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_SOF_FIRST  = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_SOF_SECOND = 1'b1;

    typedef enum logic [2:0] {
        PH_SOF0,
        PH_SOF1,
        PH_ID,
        PH_LENH,
        PH_LENL,
        PH_DATA,
        PH_CRCH,
        PH_CRCL
    } t_phase;

    // accepted frame descriptor
    typedef struct packed {
        logic [BYTE_W-1:0] msg_id;
        logic [LEN_W-1:0]  len;
    } t_desc;

    // payload write from the parser
    typedef struct packed {
        logic              en;
        logic [OFS_W-1:0]  ofs;
        logic [BYTE_W-1:0] data;
    } t_wr;

    // crc-16/ccitt-false over one byte, msb first
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/frp_ram.sv
`default_nettype none
module frp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/frp_front.sv
`default_nettype none
module frp_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic [frp_pkg::BYTE_W-1:0]  i_rx_byte,
    input  wire logic                        i_restart,
    input  wire logic                        i_cfg_we,
    input  wire logic [frp_pkg::CFG_IW-1:0]  i_cfg_index,
    input  wire logic [frp_pkg::BYTE_W-1:0]  i_cfg_data,
    output frp_pkg::t_wr                     o_wr,
    output logic                             o_push,
    output frp_pkg::t_desc                   o_desc
);
    import frp_pkg::*;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_sof0, r_sof1;
    logic [BYTE_W-1:0] r_msg_id, n_msg_id;
    logic [BYTE_W-1:0] r_len_hi, n_len_hi;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    logic [CRC_W-1:0]  r_crc, n_crc;
    logic [BYTE_W-1:0] r_crc_hi, n_crc_hi;
    logic [CRC_W-1:0]  crc_upd;
    logic [CRC_W-1:0]  len_full;
    logic              oversize;
    logic [LEN_W-1:0]  cnt_inc;

    assign crc_upd  = crc16_byte(r_crc, i_rx_byte);
    assign len_full = {r_len_hi, i_rx_byte};
    assign oversize = len_full > CRC_W'(PAYLOAD_BYTES);
    assign cnt_inc  = r_cnt + LEN_W'(1);

    // start byte registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sof0 <= SOF0_RST;
            r_sof1 <= SOF1_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SOF_FIRST:  r_sof0 <= i_cfg_data;
                CFG_SOF_SECOND: r_sof1 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            if (i_restart) begin
                n_phase = PH_SOF0;
            end else begin
                case (r_phase)
                    PH_SOF0: if (i_rx_byte == r_sof0) n_phase = PH_SOF1;
                    PH_SOF1: n_phase = (i_rx_byte == r_sof1) ? PH_ID : PH_SOF0;
                    PH_ID:   n_phase = PH_LENH;
                    PH_LENH: n_phase = PH_LENL;
                    PH_LENL: begin
                        if (oversize) begin
                            n_phase = PH_SOF0;
                        end else if (len_full == '0) begin
                            n_phase = PH_CRCH;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                    PH_DATA: if (cnt_inc >= r_len) n_phase = PH_CRCH;
                    PH_CRCH: n_phase = PH_CRCL;
                    PH_CRCL: n_phase = PH_SOF0;
                    default: n_phase = PH_SOF0;
                endcase
            end
        end
    end

    // datapath and outputs
    always_comb begin
        n_msg_id = r_msg_id;
        n_len_hi = r_len_hi;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_crc    = r_crc;
        n_crc_hi = r_crc_hi;
        o_wr     = '{en: 1'b0, ofs: r_cnt[OFS_W-1:0], data: i_rx_byte};
        o_push   = 1'b0;
        o_desc   = '{msg_id: r_msg_id, len: r_len};
        if (i_accept) begin
            if (i_restart) begin
                n_cnt = '0;
                n_crc = CRC_INIT;
            end else begin
                case (r_phase)
                    PH_SOF0: ;
                    PH_SOF1: begin
                        n_cnt = '0;
                        n_crc = CRC_INIT;
                    end
                    PH_ID: begin
                        n_msg_id = i_rx_byte;
                        n_crc    = crc_upd;
                    end
                    PH_LENH: begin
                        n_len_hi = i_rx_byte;
                        n_crc    = crc_upd;
                    end
                    PH_LENL: begin
                        n_len = len_full[LEN_W-1:0];
                        n_cnt = '0;
                        n_crc = oversize ? CRC_INIT : crc_upd;
                    end
                    PH_DATA: begin
                        o_wr.en = 1'b1;
                        n_cnt   = cnt_inc;
                        n_crc   = crc_upd;
                    end
                    PH_CRCH: n_crc_hi = i_rx_byte;
                    PH_CRCL: begin
                        o_push = ({r_crc_hi, i_rx_byte} == r_crc);
                        n_cnt  = '0;
                        n_crc  = CRC_INIT;
                    end
                    default: ;
                endcase
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SOF0;
            r_cnt    <= '0;
            r_crc    <= CRC_INIT;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_crc    <= n_crc;
        end
    end

    // header fields
    always_ff @(posedge i_clk) begin
        r_msg_id <= n_msg_id;
        r_len_hi <= n_len_hi;
        r_len    <= n_len;
        r_crc_hi <= n_crc_hi;
    end

endmodule
`default_nettype wire

FILE: rtl/core/frp_dq.sv
`default_nettype none
module frp_dq (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire frp_pkg::t_desc              i_desc,
    input  wire logic                        i_pop,
    output logic                             o_full,
    output logic                             o_valid,
    output frp_pkg::t_desc                   o_head,
    output logic [frp_pkg::BANK_W-1:0]       o_wr_bank,
    output logic [frp_pkg::BANK_W-1:0]       o_rd_bank
);
    import frp_pkg::*;

    t_desc             r_mem [BANKS];
    logic [BANK_W-1:0] r_wp, r_rp;
    logic [BANK_W:0]   r_cnt;

    assign o_full    = (r_cnt == (BANK_W+1)'(BANKS));
    assign o_valid   = (r_cnt != '0);
    assign o_head    = r_mem[r_rp];
    assign o_wr_bank = r_wp;
    assign o_rd_bank = r_rp;

    // pointers and occupancy; an entry owns the payload bank of the same slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + BANK_W'(1);
            if (i_pop)  r_rp <= r_rp + BANK_W'(1);
            r_cnt <= r_cnt + (BANK_W+1)'(i_push) - (BANK_W+1)'(i_pop);
        end
    end

    // descriptor slots
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop)) else $error("descriptor queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("descriptor queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (BANK_W+1)'(BANKS)) else $error("descriptor count out of range");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/frp_back.sv
`default_nettype none
module frp_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_head_valid,
    input  wire frp_pkg::t_desc              i_head,
    input  wire logic [frp_pkg::BANK_W-1:0]  i_head_bank,
    output logic                             o_desc_pop,
    output logic                             o_re,
    output logic [frp_pkg::RAM_AW-1:0]       o_raddr,
    input  wire logic [frp_pkg::BYTE_W-1:0]  i_rdata,
    input  wire logic                        i_pop,
    output logic                             o_empty,
    output logic [frp_pkg::BYTE_W-1:0]       o_msg_id,
    output logic [frp_pkg::LEN_W-1:0]        o_frame_length,
    output logic [frp_pkg::BYTE_W-1:0]       o_data_byte,
    output logic [frp_pkg::IDX_W-1:0]        o_byte_index,
    output logic                             o_has_data,
    output logic                             o_last
);
    import frp_pkg::*;

    logic [IDX_W-1:0]  r_idx;
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_msg_id;
    logic [LEN_W-1:0]  r_s1_len;
    logic [IDX_W-1:0]  r_s1_idx;
    logic              r_s1_has_data;
    logic              r_s1_last;
    logic              r_out_valid;
    logic              out_free, s1_move, s1_free, issue, is_last;

    // handshake between read stage and output register
    assign out_free = !r_out_valid || i_pop;
    assign s1_move  = r_s1_valid && out_free;
    assign s1_free  = !r_s1_valid || s1_move;
    assign issue    = i_head_valid && s1_free;
    assign is_last  = (i_head.len == '0) ||
                      ((LEN_W'(r_idx) + LEN_W'(1)) == i_head.len);

    assign o_desc_pop = issue && is_last;
    assign o_re       = issue;
    assign o_raddr    = {i_head_bank, r_idx[OFS_W-1:0]};
    assign o_empty    = !r_out_valid;

    // byte counter through the head frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (issue) begin
            r_idx <= is_last ? '0 : r_idx + IDX_W'(1);
        end
    end

    // read stage valid and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free)  r_s1_valid  <= issue;
            if (out_free) r_out_valid <= r_s1_valid;
        end
    end

    // read stage word
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_msg_id   <= i_head.msg_id;
            r_s1_len      <= i_head.len;
            r_s1_idx      <= r_idx;
            r_s1_has_data <= (i_head.len != '0);
            r_s1_last     <= is_last;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            o_msg_id       <= r_s1_msg_id;
            o_frame_length <= r_s1_len;
            o_data_byte    <= r_s1_has_data ? i_rdata : '0;
            o_byte_index   <= r_s1_idx;
            o_has_data     <= r_s1_has_data;
            o_last         <= r_s1_last;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/crc_checked_frame_receiver.sv
// a good frame's first word, after its last crc byte, goes via the descriptor queue,
// read stage and output register, then one word per cycle while pop is held; an empty
// frame gives one word. throughput: one received byte per cycle unless full, which
// rises only while two good frames still wait to drain, as each holds a payload bank
// reset: synchronous, active low; clears control state and restores the start bytes,
// the payload buffer is not cleared and needs no clearing pass
`default_nettype none
module crc_checked_frame_receiver (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [frp_pkg::BYTE_W-1:0]  i_rx_byte,
    input  wire logic                        i_restart,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [frp_pkg::BYTE_W-1:0]       o_msg_id,
    output logic [frp_pkg::LEN_W-1:0]        o_frame_length,
    output logic [frp_pkg::BYTE_W-1:0]       o_data_byte,
    output logic [frp_pkg::IDX_W-1:0]        o_byte_index,
    output logic                             o_has_data,
    output logic                             o_last,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [frp_pkg::CFG_IW-1:0]  i_cfg_index,
    input  wire logic [frp_pkg::BYTE_W-1:0]  i_cfg_data
);
    import frp_pkg::*;

    logic              accept;
    t_wr               wr;
    logic              desc_push, desc_pop, q_full, q_valid;
    t_desc             desc_in, head;
    logic [BANK_W-1:0] wr_bank, rd_bank;
    logic              re;
    logic [RAM_AW-1:0] raddr;
    logic [BYTE_W-1:0] rdata;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign accept      = push && !q_full;

    // parser, crc check and payload capture
    frp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_restart   (i_restart),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_wr        (wr),
        .o_push      (desc_push),
        .o_desc      (desc_in)
    );

    // good-frame queue between parser and drain
    frp_dq u_dq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (desc_push),
        .i_desc    (desc_in),
        .i_pop     (desc_pop),
        .o_full    (q_full),
        .o_valid   (q_valid),
        .o_head    (head),
        .o_wr_bank (wr_bank),
        .o_rd_bank (rd_bank)
    );

    // two-bank payload buffer
    frp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr ({wr_bank, wr.ofs}),
        .i_wdata (wr.data),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // frame drain to the result side
    frp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (q_valid),
        .i_head         (head),
        .i_head_bank    (rd_bank),
        .o_desc_pop     (desc_pop),
        .o_re           (re),
        .o_raddr        (raddr),
        .i_rdata        (rdata),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_msg_id       (o_msg_id),
        .o_frame_length (o_frame_length),
        .o_data_byte    (o_data_byte),
        .o_byte_index   (o_byte_index),
        .o_has_data     (o_has_data),
        .o_last         (o_last)
    );

`ifndef NO_ASSERTIONS
    a_bank_private: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr.en && q_valid) |-> (wr_bank != rd_bank))
        else $error("payload write hit a bank still draining");
    a_read_has_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        re |-> q_valid) else $error("payload read with no frame queued");
    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        desc_push |-> !$past(q_full) || !q_full || desc_pop)
        else $error("good frame pushed with no free bank");
`endif

endmodule
`default_nettype wire
